>>> rtl/ttm_pkg.sv
`default_nettype none

package ttm_pkg;

  localparam int SPEED_W   = 30;
  localparam int CAP_W     = 32;
  localparam int TIME_W    = 64;
  localparam int DIVSR_W   = 16;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int S_DATA_W  = 96;
  localparam int M_DATA_W  = 64;

  // Shared divider: numerator wide enough for a sum over sixteen speeds
  localparam int DIV_NUM_W   = 36;
  localparam int DIV_DEN_W   = 32;
  localparam int DIV_RADIX_W = 4;
  localparam int DIV_STEPS   = DIV_NUM_W / DIV_RADIX_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [2:0] REG_PULSE_RATE = 3'd0;
  localparam logic [2:0] REG_SMOOTH_DIV = 3'd1;
  localparam logic [2:0] REG_ON_THRESH  = 3'd2;
  localparam logic [2:0] REG_OFF_THRESH = 3'd3;
  localparam logic [2:0] REG_STALL      = 3'd4;

  localparam logic [SPEED_W-1:0] PULSE_RATE_RST = 30'd120000000;
  localparam logic [DIVSR_W-1:0] SMOOTH_DIV_RST = 16'd10;
  localparam logic [SPEED_W-1:0] ON_THRESH_RST  = 30'd2000;
  localparam logic [SPEED_W-1:0] OFF_THRESH_RST = 30'd1000;
  localparam logic [CAP_W-1:0]   STALL_RST      = 32'd100000;
  localparam logic [CAP_W-1:0]   ENTRY_RST      = 32'hFFFF_FFFF;
  localparam logic [CAP_W-1:0]   ELAPSED_LIMIT  = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_ENTRY,
    ST_ENTRY_WAIT,
    ST_TRIM,
    ST_RAW,
    ST_RAW_WAIT,
    ST_SMOOTH_PREP,
    ST_SMOOTH,
    ST_SMOOTH_WAIT,
    ST_FINISH
  } ttm_state_t;

  typedef enum logic [1:0] {
    DIV_ENTRY,
    DIV_RAW,
    DIV_SMOOTH
  } div_sel_t;

  typedef struct packed {
    logic     latch_item;
    logic     do_capture;
    logic     do_elapsed;
    logic     do_check;
    logic     entry_accum;
    logic     entry_skip;
    logic     entry_next;
    logic     div_start;
    div_sel_t div_sel;
    logic     do_trim;
    logic     raw_load;
    logic     smooth_prep;
    logic     smooth_load;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op;
    logic entry_zero;
    logic entry_last;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/ttm_div.sv
`default_nettype none

module ttm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ttm_pkg::DIV_NUM_W-1:0] numer,
  input  wire logic [ttm_pkg::DIV_DEN_W-1:0] denom,
  output logic                               busy,
  output logic                               done,
  output logic [ttm_pkg::DIV_NUM_W-1:0]      quot
);
  import ttm_pkg::*;

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_NUM_W-1:0] num_next;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;

  // Restoring division, several quotient bits per cycle; quotient shifts into num
  always_comb begin
    logic [DIV_DEN_W:0]   t;
    logic [DIV_DEN_W-1:0] r;
    logic [DIV_NUM_W-1:0] n;
    r = rem;
    n = num;
    t = '0;
    for (int k = 0; k < DIV_RADIX_W; k++) begin
      t = {r, n[DIV_NUM_W-1]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        n = {n[DIV_NUM_W-2:0], 1'b1};
      end else begin
        n = {n[DIV_NUM_W-2:0], 1'b0};
      end
      r = t[DIV_DEN_W-1:0];
    end
    num_next = n;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= numer;
      den <= denom;
      rem <= '0;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quot = num;

endmodule

`default_nettype wire

>>> rtl/ttm_ctrl.sv
`default_nettype none

module ttm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire ttm_pkg::dp_status_t status,
  output ttm_pkg::ctrl_cmd_t       cmd
);
  import ttm_pkg::*;

  ttm_state_t state;
  ttm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = (status.op == OP_CAPTURE) ? ST_FINISH : ST_CHECK;
      end
      ST_CHECK: state_next = ST_ENTRY;
      ST_ENTRY: begin
        if (!status.entry_zero) begin
          state_next = ST_ENTRY_WAIT;
        end else if (status.entry_last) begin
          state_next = ST_TRIM;
        end
      end
      ST_ENTRY_WAIT: begin
        if (status.div_done) begin
          state_next = status.entry_last ? ST_TRIM : ST_ENTRY;
        end
      end
      ST_TRIM: state_next = ST_RAW;
      ST_RAW: state_next = ST_RAW_WAIT;
      ST_RAW_WAIT: begin
        if (status.div_done) state_next = ST_SMOOTH_PREP;
      end
      ST_SMOOTH_PREP: state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = ST_SMOOTH_WAIT;
      ST_SMOOTH_WAIT: begin
        if (status.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DIV_ENTRY;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.latch_item = s_tvalid;
      end
      ST_DECODE: begin
        cmd.do_capture = (status.op == OP_CAPTURE);
        cmd.do_elapsed = (status.op == OP_UPDATE);
      end
      ST_CHECK: cmd.do_check = 1'b1;
      ST_ENTRY: begin
        if (status.entry_zero) begin
          // zero interval counts as zero speed
          cmd.entry_accum = 1'b1;
          cmd.entry_skip  = 1'b1;
          cmd.entry_next  = !status.entry_last;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ENTRY;
        end
      end
      ST_ENTRY_WAIT: begin
        cmd.entry_accum = status.div_done;
        cmd.entry_next  = status.div_done && !status.entry_last;
      end
      ST_TRIM: cmd.do_trim = 1'b1;
      ST_RAW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RAW;
      end
      ST_RAW_WAIT: cmd.raw_load = status.div_done;
      ST_SMOOTH_PREP: cmd.smooth_prep = 1'b1;
      ST_SMOOTH: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SMOOTH;
      end
      ST_SMOOTH_WAIT: cmd.smooth_load = status.div_done;
      ST_FINISH: cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ttm_datapath.sv
`default_nettype none

module ttm_datapath #(
  parameter int RING_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ttm_pkg::SPEED_W-1:0]   pulse_rate,
  input  wire logic [ttm_pkg::DIVSR_W-1:0]   smoothing_divisor,
  input  wire logic [ttm_pkg::SPEED_W-1:0]   engine_on_threshold,
  input  wire logic [ttm_pkg::SPEED_W-1:0]   engine_off_threshold,
  input  wire logic [ttm_pkg::CAP_W-1:0]     stall_interval,
  input  wire logic [ttm_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ttm_pkg::M_DATA_W-1:0]       m_tdata,
  input  wire ttm_pkg::ctrl_cmd_t            cmd,
  output ttm_pkg::dp_status_t                status
);
  import ttm_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = SPEED_W + $clog2(RING_DEPTH);

  // latched word
  logic              item_op;
  logic [CAP_W-1:0]  item_cap;
  logic [TIME_W-1:0] item_now;

  logic [CAP_W-1:0]  ring [RING_DEPTH];
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  pos_next;
  logic              awaiting;
  logic [CAP_W-1:0]  prev_cap;
  logic [TIME_W-1:0] prev_time;
  logic [TIME_W-1:0] elapsed;

  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   sum;
  logic [SPEED_W-1:0] lo;
  logic [SPEED_W-1:0] hi;
  logic [SUM_W-1:0]   trimmed;
  logic               diff_neg;
  logic [SPEED_W-1:0] diff_mag;

  logic [SPEED_W-1:0] raw;
  logic [SPEED_W-1:0] display;
  logic               flag;

  logic               push_en;
  logic [CAP_W-1:0]   push_val;
  logic               stall_hit;
  logic [SPEED_W-1:0] speed;
  logic [SPEED_W:0]   diff;
  logic               flag_next;

  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_numer;
  logic [DIV_DEN_W-1:0] div_denom;
  logic [DIV_NUM_W-1:0] div_quot;

  ttm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    case (cmd.div_sel)
      DIV_ENTRY: begin
        div_numer = DIV_NUM_W'(pulse_rate);
        div_denom = ring[idx];
      end
      DIV_RAW: begin
        div_numer = DIV_NUM_W'(trimmed);
        div_denom = DIV_DEN_W'(RING_DEPTH - 2);
      end
      DIV_SMOOTH: begin
        div_numer = DIV_NUM_W'(diff_mag);
        div_denom = (smoothing_divisor == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(smoothing_divisor);
      end
      default: begin
        div_numer = '0;
        div_denom = DIV_DEN_W'(1);
      end
    endcase
  end

  // Elapsed time pushes only when it is below the all-ones 32-bit limit and reaches the stall interval
  assign stall_hit = (elapsed[TIME_W-1:CAP_W] == '0) &&
                     (elapsed[CAP_W-1:0] != ELAPSED_LIMIT) &&
                     (elapsed[CAP_W-1:0] >= stall_interval);

  always_comb begin
    push_en  = 1'b0;
    push_val = item_cap - prev_cap;
    if (cmd.do_capture && !awaiting) begin
      push_en = 1'b1;
    end else if (cmd.do_check && stall_hit) begin
      push_en  = 1'b1;
      push_val = elapsed[CAP_W-1:0];
    end
  end

  assign pos_next = (pos == IDX_W'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= ENTRY_RST;
      end
      pos       <= '0;
      awaiting  <= 1'b1;
      prev_time <= '0;
    end else begin
      if (push_en) begin
        ring[pos] <= push_val;
        pos       <= pos_next;
      end
      if (cmd.do_capture) begin
        awaiting  <= 1'b0;
        prev_time <= item_now;
      end else if (cmd.do_check && stall_hit) begin
        awaiting <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_op  <= s_tuser;
      item_cap <= s_tdata[CAP_W-1:0];
      item_now <= s_tdata[CAP_W +: TIME_W];
    end
    if (cmd.do_capture) prev_cap <= item_cap;
    if (cmd.do_elapsed) elapsed <= item_now - prev_time;
  end

  // Per-entry speed accumulation
  assign speed = cmd.entry_skip ? '0 : div_quot[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.do_check) begin
      idx <= '0;
      sum <= '0;
      lo  <= '1;
      hi  <= '0;
    end else begin
      if (cmd.entry_accum) begin
        sum <= sum + SUM_W'(speed);
        if (speed < lo) lo <= speed;
        if (speed > hi) hi <= speed;
      end
      if (cmd.entry_next) idx <= idx + 1'b1;
    end
    if (cmd.do_trim) trimmed <= sum - SUM_W'(lo) - SUM_W'(hi);
    if (cmd.smooth_prep) begin
      diff_neg <= diff[SPEED_W];
      diff_mag <= diff[SPEED_W] ? SPEED_W'(-diff) : diff[SPEED_W-1:0];
    end
  end

  assign diff      = {1'b0, raw} - {1'b0, display};
  assign flag_next = (flag || (raw >= engine_on_threshold)) && !(raw <= engine_off_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw     <= '0;
      display <= '0;
      flag    <= 1'b0;
    end else begin
      if (cmd.raw_load) raw <= div_quot[SPEED_W-1:0];
      if (cmd.smooth_load) begin
        // step is truncated toward zero, so display never passes raw
        display <= diff_neg ? display - div_quot[SPEED_W-1:0]
                            : display + div_quot[SPEED_W-1:0];
        flag    <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {(M_DATA_W - 2 * SPEED_W - 1)'(0), flag, display, raw};
    end
  end

  assign status.op         = item_op;
  assign status.entry_zero = (ring[idx] == '0);
  assign status.entry_last = (idx == IDX_W'(RING_DEPTH - 1));
  assign status.div_done   = div_done;
  assign status.out_busy   = m_tvalid && !m_tready;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= IDX_W'(RING_DEPTH - 1))
    else $error("ring position beyond ring depth");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("output word overwritten while stalled");

  a_push_once: assert property (@(posedge clk) disable iff (rst)
    cmd.do_capture |-> !cmd.do_check)
    else $error("capture and stall push in the same cycle");

endmodule

`default_nettype wire

>>> rtl/tachometer_trimmed_mean.sv
// Pulse-period tachometer with trimmed-mean speed, smoothed display and engine flag.
// Input stream (s_*): s_tuser is the kind (0 capture edge, 1 update tick); s_tdata
// carries the capture count and the microsecond timestamp. Every word gives one
// output word (m_*): raw speed, display speed and the engine flag.
// Configuration goes through the APB port: pulse rate, smoothing divisor, on and off
// thresholds, stall interval at byte addresses 0, 4, 8, 12, 16; write only while idle.
// One word is in flight at a time. A capture edge passes from accept through the decode
// and finish states to the result. An update tick runs every ring entry, then the raw
// average and the display step, through one shared 4-bit-per-cycle divider; each zero
// ring entry counts as zero speed and skips its division, so the tick ends sooner.
// The result sits in an output register; while the receiver stalls the block finishes
// the next word and then holds it until the register frees, with s_tready low.
// Reset fills the ring with all-ones intervals, clears speeds and flag, restores the
// register defaults and arms first-capture mode; no clearing pass is needed.
`default_nettype none

module tachometer_trimmed_mean #(
  parameter int RING_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ttm_pkg::S_DATA_W-1:0]  s_tdata,   // capture_value[31:0], now_time[95:32]
  input  wire logic                          s_tuser,   // operation
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ttm_pkg::M_DATA_W-1:0]       m_tdata,   // raw_speed[29:0], display_speed[59:30],
                                                        // engine_running[60], zero[63:61]
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ttm_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [ttm_pkg::CFG_DW-1:0]    pwdata,
  output logic [ttm_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);
  import ttm_pkg::*;

  logic [SPEED_W-1:0] pulse_rate;
  logic [DIVSR_W-1:0] smoothing_divisor;
  logic [SPEED_W-1:0] engine_on_threshold;
  logic [SPEED_W-1:0] engine_off_threshold;
  logic [CAP_W-1:0]   stall_interval;
  logic               cfg_wr;
  logic [2:0]         reg_idx;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_rate           <= PULSE_RATE_RST;
      smoothing_divisor    <= SMOOTH_DIV_RST;
      engine_on_threshold  <= ON_THRESH_RST;
      engine_off_threshold <= OFF_THRESH_RST;
      stall_interval       <= STALL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PULSE_RATE: pulse_rate           <= pwdata[SPEED_W-1:0];
        REG_SMOOTH_DIV: smoothing_divisor    <= pwdata[DIVSR_W-1:0];
        REG_ON_THRESH:  engine_on_threshold  <= pwdata[SPEED_W-1:0];
        REG_OFF_THRESH: engine_off_threshold <= pwdata[SPEED_W-1:0];
        REG_STALL:      stall_interval       <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE_RATE: prdata = CFG_DW'(pulse_rate);
      REG_SMOOTH_DIV: prdata = CFG_DW'(smoothing_divisor);
      REG_ON_THRESH:  prdata = CFG_DW'(engine_on_threshold);
      REG_OFF_THRESH: prdata = CFG_DW'(engine_off_threshold);
      REG_STALL:      prdata = stall_interval;
      default:        prdata = '0;
    endcase
  end

  ttm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ttm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .pulse_rate           (pulse_rate),
    .smoothing_divisor    (smoothing_divisor),
    .engine_on_threshold  (engine_on_threshold),
    .engine_off_threshold (engine_off_threshold),
    .stall_interval       (stall_interval),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .cmd                  (cmd),
    .status               (status)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_tachometer_trimmed_mean.sv
`timescale 1ns / 1ps

module tb_tachometer_trimmed_mean;
  import ttm_pkg::*;

  localparam int DEPTH       = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic [SPEED_W-1:0] raw;
    logic [SPEED_W-1:0] disp;
    logic               eng;
  } speed_word_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  wire                 s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = OP_CAPTURE;
  wire                 m_tvalid;
  logic                m_tready = 1'b0;
  wire  [M_DATA_W-1:0] m_tdata;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [CFG_AW-1:0]   paddr    = '0;
  logic [CFG_DW-1:0]   pwdata   = '0;
  wire  [CFG_DW-1:0]   prdata;
  wire                 pready;

  // predictor copy of configuration and state
  logic [SPEED_W-1:0] cfg_rate  = PULSE_RATE_RST;
  logic [DIVSR_W-1:0] cfg_div   = SMOOTH_DIV_RST;
  logic [SPEED_W-1:0] cfg_on    = ON_THRESH_RST;
  logic [SPEED_W-1:0] cfg_off   = OFF_THRESH_RST;
  logic [CAP_W-1:0]   cfg_stall = STALL_RST;

  logic [CAP_W-1:0]   ring [DEPTH];
  int                 ring_pos       = 0;
  logic               wait_first     = 1'b1;
  logic [CAP_W-1:0]   last_cap       = '0;
  logic [TIME_W-1:0]  last_edge_time = '0;
  logic [SPEED_W-1:0] raw_q          = '0;
  logic [SPEED_W-1:0] disp_q         = '0;
  logic               eng_q          = 1'b0;

  speed_word_t        speed_expect_q [$];
  int                 err_count    = 0;
  int                 result_count = 0;
  longint             cycle_count  = 0;
  logic               idle_on      = 1'b1;
  logic [CAP_W-1:0]   gen_cap      = '0;
  logic [TIME_W-1:0]  gen_time     = '0;

  tachometer_trimmed_mean #(
    .RING_DEPTH(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tachometer_trimmed_mean] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
    err_count++;
  endtask

  task automatic push_interval(input logic [CAP_W-1:0] v);
    ring[ring_pos] = v;
    ring_pos = (ring_pos == DEPTH - 1) ? 0 : ring_pos + 1;
  endtask

  // advance the predicted tachometer by one accepted word and queue its result
  task automatic tach_predict(input logic op, input logic [CAP_W-1:0] cap,
                              input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    longint unsigned   total;
    logic [CAP_W-1:0]  lo;
    logic [CAP_W-1:0]  hi;
    logic [CAP_W-1:0]  spd;
    longint            dv;
    longint            a;
    longint            b;
    longint            nudge;
    speed_word_t       w;
    if (op == OP_CAPTURE) begin
      if (!wait_first) push_interval(cap - last_cap);
      wait_first     = 1'b0;
      last_cap       = cap;
      last_edge_time = now;
    end else begin
      elapsed = now - last_edge_time;
      if (elapsed < 64'h0000_0000_FFFF_FFFF && elapsed >= {32'h0, cfg_stall}) begin
        push_interval(elapsed[CAP_W-1:0]);
        wait_first = 1'b1;
      end
      total = 0;
      lo    = '1;
      hi    = '0;
      for (int i = 0; i < DEPTH; i++) begin
        spd = (ring[i] != 0) ? {2'b00, cfg_rate} / ring[i] : '0;
        total += spd;
        if (spd < lo) lo = spd;
        if (spd > hi) hi = spd;
      end
      raw_q = SPEED_W'((total - lo - hi) / (DEPTH - 2));
      // zero divisor acts as one
      dv     = (cfg_div == 0) ? 1 : cfg_div;
      a      = raw_q;
      b      = disp_q;
      nudge  = (a - b) / dv;
      disp_q = SPEED_W'(b + nudge);
      if (!eng_q && raw_q >= cfg_on) eng_q = 1'b1;
      if (eng_q && raw_q <= cfg_off) eng_q = 1'b0;
    end
    w.raw  = raw_q;
    w.disp = disp_q;
    w.eng  = eng_q;
    speed_expect_q.push_back(w);
  endtask

  task automatic send_word(input logic op, input logic [CAP_W-1:0] cap,
                           input logic [TIME_W-1:0] now);
    int   gap;
    logic ready;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, cap};
    do begin
      @(negedge clk);
      ready = s_tready;
      @(posedge clk);
    end while (!ready);
    tach_predict(op, cap, now);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (speed_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
    logic rdy;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PULSE_RATE: cfg_rate  = val[SPEED_W-1:0];
      REG_SMOOTH_DIV: cfg_div   = val[DIVSR_W-1:0];
      REG_ON_THRESH:  cfg_on    = val[SPEED_W-1:0];
      REG_OFF_THRESH: cfg_off   = val[SPEED_W-1:0];
      REG_STALL:      cfg_stall = val;
      default: ;
    endcase
    // bus goes idle between transfers
    @(posedge clk);
  endtask

  task automatic cfg_all(input logic [CFG_DW-1:0] rate, input logic [CFG_DW-1:0] div,
                         input logic [CFG_DW-1:0] on, input logic [CFG_DW-1:0] off,
                         input logic [CFG_DW-1:0] stall);
    wait_idle();
    cfg_write(REG_PULSE_RATE, rate);
    cfg_write(REG_SMOOTH_DIV, div);
    cfg_write(REG_ON_THRESH, on);
    cfg_write(REG_OFF_THRESH, off);
    cfg_write(REG_STALL, stall);
  endtask

  // mostly steady pulse trains with periodic ticks, some stalls and some noise
  task automatic run_traffic(input int n);
    int                pick;
    logic [CAP_W-1:0]  period;
    logic [TIME_W-1:0] now64;
    period = 32'd1000;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       period = $urandom_range(0, 64);
          1:       period = $urandom_range(100, 5000);
          2:       period = $urandom_range(10000, 2000000);
          default: period = $urandom;
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        now64    = {$urandom, $urandom};
        gen_time = now64;
        send_word(logic'($urandom_range(0, 1)), $urandom, now64);
      end else if (pick < 12) begin
        // land on either side of the stall interval
        if ($urandom_range(0, 3) == 0) now64 = last_edge_time + {$urandom, $urandom};
        else now64 = last_edge_time + cfg_stall - 1 + $urandom_range(0, 2);
        gen_time = now64;
        send_word(OP_UPDATE, $urandom, now64);
      end else if (pick < 40) begin
        gen_time += $urandom_range(0, 3000);
        send_word(OP_UPDATE, $urandom, gen_time);
      end else begin
        gen_cap  += period + $urandom_range(0, period >> 3);
        gen_time += $urandom_range(1, 3000);
        send_word(OP_CAPTURE, gen_cap, gen_time);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_word(OP_UPDATE, 32'h0, 64'd0);
    send_word(OP_UPDATE, 32'h5A5A_5A5A, 64'd99_999);
    send_word(OP_UPDATE, 32'h0, 64'd100_000);
  endtask

  task automatic test_directed_cases();
    logic [TIME_W-1:0] t;
    t = 64'd1_000_000;
    // four equal intervals reach the on threshold exactly
    send_word(OP_CAPTURE, 32'd0, t);
    send_word(OP_CAPTURE, 32'd60000, t + 1000);
    send_word(OP_CAPTURE, 32'd120000, t + 2000);
    send_word(OP_CAPTURE, 32'd180000, t + 3000);
    send_word(OP_CAPTURE, 32'd240000, t + 4000);
    send_word(OP_UPDATE, 32'h0, t + 5000);
    // counter wrap, zero interval and unit interval
    send_word(OP_CAPTURE, 32'hFFFF_FFFF, t + 6000);
    send_word(OP_CAPTURE, 32'h0000_0001, t + 7000);
    send_word(OP_CAPTURE, 32'h0000_0001, t + 8000);
    send_word(OP_CAPTURE, 32'h0000_0002, t + 9000);
    send_word(OP_UPDATE, 32'hFFFF_FFFF, t + 9000);
    send_word(OP_UPDATE, 32'h0, t + 9000 + 99_999);
    send_word(OP_UPDATE, 32'h0, t + 9000 + 100_000);
    // first edge after a stall stores nothing
    send_word(OP_CAPTURE, 32'h8000_0000, t + 200_000);
    send_word(OP_UPDATE, 32'h0, t + 200_000 + 64'hFFFF_FFFE);
    send_word(OP_UPDATE, 32'h0, t + 200_000 + 64'hFFFF_FFFF);
    send_word(OP_UPDATE, 32'h0, t + 200_000 - 1);
    send_word(OP_UPDATE, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_CAPTURE, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
    send_word(OP_CAPTURE, 32'h8003_A97F, 64'h10);
    send_word(OP_UPDATE, 32'h0, 64'h1_0000);
    // long stalls drag the raw speed further down below the off threshold
    send_word(OP_UPDATE, 32'h0, 64'h10 + 10_000_000);
    send_word(OP_UPDATE, 32'h0, 64'h10 + 20_000_000);
    send_word(OP_UPDATE, 32'h0, 64'h10 + 30_000_000);
    send_word(OP_UPDATE, 32'h0, 64'h10 + 40_000_000);
  endtask

  task automatic test_config_extremes();
    gen_cap  = 32'hFFFF_0000;
    gen_time = 64'd50_000_000;
    cfg_all(32'd1_000_000_000, 32'd1, 32'd0, 32'd0, 32'd1);
    run_traffic(40);
    cfg_all(32'd1, 32'd65535, 32'd1_000_000_000, 32'd1_000_000_000, 32'hFFFF_FFFF);
    run_traffic(40);
    // zero smoothing divisor
    cfg_all(32'd120_000_000, 32'd0, 32'd2000, 32'd1000, 32'd100_000);
    run_traffic(40);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DW-1:0] rate;
    logic [CFG_DW-1:0] div;
    logic [CFG_DW-1:0] on;
    logic [CFG_DW-1:0] off;
    logic [CFG_DW-1:0] stall;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0:       rate = 32'd1_000_000_000;
        1:       rate = $urandom_range(1, 1_000_000_000);
        2:       rate = 32'd120_000_000;
        default: rate = $urandom_range(1, 100_000);
      endcase
      case ($urandom_range(0, 3))
        0:       div = 32'd1;
        1:       div = 32'd65535;
        default: div = $urandom_range(1, 32);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        on  = $urandom_range(0, 1_000_000_000);
        off = $urandom_range(0, 1_000_000_000);
      end else begin
        off = $urandom_range(0, 2_000_000);
        on  = off + $urandom_range(0, 2_000_000);
      end
      case ($urandom_range(0, 3))
        0:       stall = $urandom_range(1, 1000);
        1:       stall = $urandom_range(1000, 500_000);
        2:       stall = 32'hFFFF_FFFF;
        default: stall = $urandom;
      endcase
      if (stall == 0) stall = 32'd1;
      cfg_all(rate, div, on, off, stall);
      run_traffic(230);
    end
  endtask

  // result side: random backpressure, compare against the oldest prediction
  initial begin
    int          hold;
    logic        seen;
    logic [63:0] word;
    speed_word_t want;
    while (rst) @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = m_tvalid;
        word = m_tdata;
        @(posedge clk);
      end while (!seen);
      result_count++;
      if (speed_expect_q.size() == 0) begin
        report_mismatch("unexpected word", word, 64'd0);
      end else begin
        want = speed_expect_q.pop_front();
        if (word[29:0] !== want.raw) report_mismatch("raw_speed", word[29:0], want.raw);
        if (word[59:30] !== want.disp)
          report_mismatch("display_speed", word[59:30], want.disp);
        if (word[60] !== want.eng) report_mismatch("engine_running", word[60], want.eng);
      end
    end
  end

  initial begin
    foreach (ring[i]) ring[i] = ENTRY_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[tachometer_trimmed_mean] OK");
    end else begin
      $display("[tachometer_trimmed_mean] ERROR");
    end
    $finish;
  end

endmodule
